// ===== src/bmmc_pkg.sv =====
// shared types and constants for the barcode minimum-mismatch counter
// no dependencies; imported by every module of the block
package bmmc_pkg;

	localparam int MAX_PRIMERS = 6;
	localparam int PRIMER_REGS = 6;
	localparam int COUNT_WIDTH = 32;
	localparam int TAG_LEN     = 6;
	localparam int TAG_W       = 8 * TAG_LEN;
	localparam int POS_W       = $clog2(TAG_LEN + 1);
	localparam int MISM_W      = 3;
	localparam int ADDR_W      = 6;
	localparam int DATA_W      = 64;
	localparam int TOTAL_W     = 32;

	localparam logic [7:0] HASH_CHAR = 8'h23;

	// register indexes (byte address is 8 * index)
	localparam logic [2:0] REG_PRIMER_COUNT = 3'd0;
	localparam logic [2:0] REG_PRIMER_FIRST = 3'd1;

	// completed read handed from tag capture to scoring
	typedef struct packed {
		logic             valid;
		logic             counted;
		logic [TAG_W-1:0] tag;
	} tag_item_t;

	// configuration register contents
	typedef struct packed {
		logic [2:0]                        count;
		logic [PRIMER_REGS-1:0][TAG_W-1:0] primer;
	} cfg_t;

endpackage

// ===== src/bmmc_regs.sv =====
// configuration register file with apb-style write and read access
// depends on bmmc_pkg
module bmmc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bmmc_pkg::ADDR_W-1:0]   paddr,
	input  logic [bmmc_pkg::DATA_W-1:0]   pwdata,
	output logic [bmmc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output bmmc_pkg::cfg_t                cfg
);
	import bmmc_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[ADDR_W-1:3];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// register writes, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			if (reg_idx == REG_PRIMER_COUNT) begin
				cfg_q.count <= pwdata[2:0];
			end
			for (int i = 0; i < PRIMER_REGS; i++) begin
				if (reg_idx == REG_PRIMER_FIRST + 3'(i)) begin
					cfg_q.primer[i] <= pwdata[TAG_W-1:0];
				end
			end
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		if (reg_idx == REG_PRIMER_COUNT) begin
			prdata = DATA_W'(cfg_q.count);
		end
		for (int i = 0; i < PRIMER_REGS; i++) begin
			if (reg_idx == REG_PRIMER_FIRST + 3'(i)) begin
				prdata = DATA_W'(cfg_q.primer[i]);
			end
		end
	end

endmodule

// ===== src/bmmc_tag_capture.sv =====
// per-byte tag tracking: finds the first '#' and collects the six bytes after it
// depends on bmmc_pkg; registers one completed read per last byte
module bmmc_tag_capture (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  accept,
	input  logic [7:0]            name_byte,
	input  logic                  last_byte,
	output bmmc_pkg::tag_item_t   item_s1
);
	import bmmc_pkg::*;

	logic             hash_seen_q;
	logic [POS_W-1:0] tag_pos_q;
	logic [TAG_W-1:0] tag_q;
	logic             hash_nxt;
	logic [POS_W-1:0] pos_nxt;
	logic [TAG_W-1:0] tag_nxt;
	logic             valid_s1;
	logic             counted_s1;
	logic [TAG_W-1:0] tag_s1;

	// next tag state for the incoming byte
	always_comb begin
		hash_nxt = hash_seen_q;
		pos_nxt  = tag_pos_q;
		tag_nxt  = tag_q;
		if (!hash_seen_q) begin
			if (name_byte == HASH_CHAR) begin
				hash_nxt = 1'b1;
				pos_nxt  = '0;
				tag_nxt  = '0;
			end
		end else if (tag_pos_q < POS_W'(TAG_LEN)) begin
			tag_nxt = {tag_q[TAG_W-9:0], name_byte};
			pos_nxt = tag_pos_q + POS_W'(1);
		end
	end

	// per-read state, cleared after every last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_seen_q <= 1'b0;
			tag_pos_q   <= '0;
			tag_q       <= '0;
		end else if (accept) begin
			if (last_byte) begin
				hash_seen_q <= 1'b0;
				tag_pos_q   <= '0;
				tag_q       <= '0;
			end else begin
				hash_seen_q <= hash_nxt;
				tag_pos_q   <= pos_nxt;
				tag_q       <= tag_nxt;
			end
		end
	end

	// stage 1 register: one entry per finished name
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept && last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && accept && last_byte) begin
			counted_s1 <= hash_nxt && (pos_nxt == POS_W'(TAG_LEN));
			tag_s1     <= tag_nxt;
		end
	end

	assign item_s1 = {valid_s1, counted_s1, tag_s1};

endmodule

// ===== src/bmmc_score.sv =====
// minimum byte-mismatch count of a tag against the active primers
// depends on bmmc_pkg; purely combinational
module bmmc_score (
	input  logic [bmmc_pkg::TAG_W-1:0]  tag,
	input  bmmc_pkg::cfg_t              cfg,
	output logic [bmmc_pkg::MISM_W-1:0] best
);
	import bmmc_pkg::*;

	logic [2:0] n_active;

	// primer count clamps at the number of primer slots
	assign n_active = (cfg.count > 3'(MAX_PRIMERS)) ? 3'(MAX_PRIMERS) : cfg.count;

	// per-primer mismatch count, then running minimum
	always_comb begin
		logic [MISM_W-1:0] miss;
		best = MISM_W'(TAG_LEN);
		for (int i = 0; i < MAX_PRIMERS; i++) begin
			miss = '0;
			for (int k = 0; k < TAG_LEN; k++) begin
				if (tag[8*k +: 8] != cfg.primer[i][8*k +: 8]) begin
					miss = miss + MISM_W'(1);
				end
			end
			if ((3'(i) < n_active) && (miss < best)) begin
				best = miss;
			end
		end
	end

endmodule

// ===== src/barcode_min_mismatch_counter.sv =====
// barcode minimum-mismatch counter: one name byte per transaction, one result per name
// an accepted last byte passes the stage 1 register, then the result register that drives result_valid
// throughput: one byte per cycle; the only stall is a held result with result_stall high
// reset (arst_n low, asynchronous): counters, tag state, registers and valids clear
// top level; depends on bmmc_pkg, bmmc_regs, bmmc_tag_capture, bmmc_score
module barcode_min_mismatch_counter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           name_valid,
	output logic                           name_stall,
	input  logic [7:0]                     name_byte,
	input  logic                           last_byte,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic                           read_counted,
	output logic [bmmc_pkg::MISM_W-1:0]    best_mismatches,
	output logic [bmmc_pkg::TOTAL_W-1:0]   reads_total,
	output logic [bmmc_pkg::TOTAL_W-1:0]   mismatches_total,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bmmc_pkg::ADDR_W-1:0]    paddr,
	input  logic [bmmc_pkg::DATA_W-1:0]    pwdata,
	output logic [bmmc_pkg::DATA_W-1:0]    prdata,
	output logic                           pready
);
	import bmmc_pkg::*;

	cfg_t                   cfg;
	tag_item_t              item_s1;
	logic                   adv;
	logic                   accept;
	logic [MISM_W-1:0]      best;
	logic                   valid_s2;
	logic                   counted_s2;
	logic [MISM_W-1:0]      best_s2;
	logic [COUNT_WIDTH-1:0] read_cnt_q;
	logic [COUNT_WIDTH-1:0] miss_sum_q;
	logic [COUNT_WIDTH:0]   miss_sum_add;

	// pipeline moves unless the held result is stalled
	assign adv        = !valid_s2 || !result_stall;
	assign name_stall = !adv;
	assign accept     = name_valid && adv;

	bmmc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bmmc_tag_capture u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.accept    (accept),
		.name_byte (name_byte),
		.last_byte (last_byte),
		.item_s1   (item_s1)
	);

	bmmc_score u_score (
		.tag  (item_s1.tag),
		.cfg  (cfg),
		.best (best)
	);

	// saturating add of the mismatch count, carry out means overflow
	assign miss_sum_add = {1'b0, miss_sum_q} + (COUNT_WIDTH + 1)'(best);

	// result register and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2   <= 1'b0;
			read_cnt_q <= '0;
			miss_sum_q <= '0;
		end else if (adv) begin
			valid_s2 <= item_s1.valid;
			if (item_s1.valid && item_s1.counted) begin
				if (read_cnt_q != '1) begin
					read_cnt_q <= read_cnt_q + COUNT_WIDTH'(1);
				end
				miss_sum_q <= miss_sum_add[COUNT_WIDTH] ? '1 : miss_sum_add[COUNT_WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && item_s1.valid) begin
			counted_s2 <= item_s1.counted;
			best_s2    <= item_s1.counted ? best : '0;
		end
	end

	assign result_valid     = valid_s2;
	assign read_counted     = counted_s2;
	assign best_mismatches  = best_s2;
	assign reads_total      = TOTAL_W'(read_cnt_q);
	assign mismatches_total = TOTAL_W'(miss_sum_q);

endmodule

// ===== src/bmmc_checker.sv =====
// port-level checks for the barcode minimum-mismatch counter, bound to the top level
// depends on bmmc_pkg and barcode_min_mismatch_counter
module bmmc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           result_valid,
	input logic                           result_stall,
	input logic                           read_counted,
	input logic [bmmc_pkg::MISM_W-1:0]    best_mismatches,
	input logic [bmmc_pkg::TOTAL_W-1:0]   reads_total,
	input logic [bmmc_pkg::TOTAL_W-1:0]   mismatches_total
);
	import bmmc_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(best_mismatches)
			&& $stable(read_counted) && $stable(reads_total))
		else $error("stalled result changed");

	// skipped reads report no mismatches
	a_skip: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !read_counted |-> best_mismatches == '0)
		else $error("skipped read with nonzero mismatches");

	// minimum never exceeds the tag length
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> best_mismatches <= MISM_W'(TAG_LEN))
		else $error("mismatch count out of range");

	// read total moves only by one, with a fresh counted result
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		reads_total != $past(reads_total) |->
			result_valid && read_counted && reads_total == $past(reads_total) + TOTAL_W'(1))
		else $error("read total changed unexpectedly");

	// mismatch total moves only with a counted result
	a_sum: assert property (@(posedge clk) disable iff (!arst_n)
		mismatches_total != $past(mismatches_total) |-> result_valid && read_counted)
		else $error("mismatch total changed unexpectedly");

endmodule

bind barcode_min_mismatch_counter bmmc_checker u_bmmc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.result_valid     (result_valid),
	.result_stall     (result_stall),
	.read_counted     (read_counted),
	.best_mismatches  (best_mismatches),
	.reads_total      (reads_total),
	.mismatches_total (mismatches_total)
);
